### src/poia_pkg.sv
// shared types and constants for the per-owner id pool allocator
// used by poia_ctrl, poia_stack_mem and per_owner_id_pool_allocator
`default_nettype none

package poia_pkg;

    localparam int FUNC_W = 3;
    localparam int OWN_W  = 3;
    localparam int ID_W   = 11;
    localparam int STAT_W = 2;
    localparam int OFF_W  = 10;
    localparam int CFG_W  = 4;
    // one extra bit over CFG_W so the reset count still fits when all owners are in use
    localparam int OIU_W  = CFG_W + 1;

    localparam int IN_TDATA_W  = ((OWN_W + ID_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ID_W + OWN_W + STAT_W + 7) / 8) * 8;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [OFF_W-1:0] OFF_MAX = 10'd1023;

    localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PICK      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RESET_ALL = 3'd4;

    localparam logic [STAT_W-1:0] STS_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STS_EMPTY       = 2'd1;
    localparam logic [STAT_W-1:0] STS_WRONG_OWNER = 2'd2;
    localparam logic [STAT_W-1:0] STS_FULL        = 2'd3;

    localparam logic [0:0] REG_OWNERS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [OWN_W-1:0]  owner;
        logic [ID_W-1:0]   id_value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OWN_W-1:0]  owner_out;
        logic [ID_W-1:0]   id_out;
    } t_res;

endpackage

`default_nettype wire

### src/poia_stack_mem.sv
// free stack storage: one write port, one read port, registered read data
// depends on poia_pkg for the id width
`default_nettype none

module poia_stack_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [poia_pkg::ID_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [poia_pkg::ID_W-1:0] o_rdata
);
    import poia_pkg::*;

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/poia_ctrl.sv
// request sequencer: per-owner counts, low-water marks and pick offsets,
// stack memory reads and writes and the serial pick scan; uses poia_pkg
`default_nettype none

module poia_ctrl #(
    parameter int OWNERS        = 8,
    parameter int IDS_PER_OWNER = 256,
    parameter int AW            = 11
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire poia_pkg::t_req             i_req,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic [poia_pkg::OIU_W-1:0] i_owners_in_use,
    output poia_pkg::t_res                  o_res,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output logic                            o_mem_we,
    output logic      [AW-1:0]              o_mem_waddr,
    output logic      [poia_pkg::ID_W-1:0]  o_mem_wdata,
    output logic                            o_mem_re,
    output logic      [AW-1:0]              o_mem_raddr,
    input  wire logic [poia_pkg::ID_W-1:0]  i_mem_rdata
);
    import poia_pkg::*;

    localparam int OW_W  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int N_W   = OW_W + 1;
    localparam int CNT_W = $clog2(IDS_PER_OWNER + 1);
    localparam int BW    = $clog2((2 ** OWN_W) * IDS_PER_OWNER + 1);
    localparam int SW    = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;
    localparam logic [CNT_W-1:0] IDS_C = CNT_W'(IDS_PER_OWNER);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_cnt [OWNERS];
    // lowest count since the last refill; entries below it still hold their initial id
    logic [CNT_W-1:0] r_low [OWNERS];
    logic [OFF_W-1:0] r_off [OWNERS];

    t_res                r_res;
    logic                r_fresh;
    logic [ID_W-1:0]     r_init_id;
    logic [OW_W-1:0]     r_idx;
    logic [OW_W-1:0]     r_best;
    logic signed [SW-1:0] r_best_score;
    logic [OFF_W-1:0]    r_best_off;

    logic                 s_accept;
    logic                 s_owner_ok;
    logic [OW_W-1:0]      s_sel;
    logic [CNT_W-1:0]     s_cnt;
    logic [CNT_W-1:0]     s_low;
    logic [OFF_W-1:0]     s_off;
    logic [CNT_W-1:0]     s_pop_c;
    logic                 s_fresh;
    logic [BW-1:0]        s_base;
    logic [BW-1:0]        s_id;
    logic                 s_in_block;
    logic [ID_W-1:0]      s_init_id;
    logic                 s_pop_ok;
    logic                 s_push_ok;
    logic [N_W-1:0]       s_n;
    logic                 s_last;
    logic signed [SW-1:0] s_score;
    logic                 s_take;
    logic [OW_W-1:0]      s_win;
    logic [OFF_W-1:0]     s_win_off;
    logic                 s_scan_done;
    logic                 s_do_reset_all;
    logic                 s_do_clear;

    assign s_accept   = i_req_valid && o_req_ready;
    assign s_owner_ok = BW'(i_req.owner) < BW'(OWNERS);

    // one shared index into the per-owner tables
    assign s_sel = (r_state == S_SCAN) ? r_idx : OW_W'(i_req.owner);
    assign s_cnt = r_cnt[s_sel];
    assign s_low = r_low[s_sel];
    assign s_off = r_off[s_sel];

    assign s_base     = BW'(i_req.owner) * BW'(IDS_PER_OWNER);
    assign s_id       = BW'(i_req.id_value);
    assign s_in_block = (s_id >= s_base) && (s_id < s_base + BW'(IDS_PER_OWNER));
    assign s_pop_c    = s_cnt - 1'b1;
    assign s_fresh    = s_pop_c < s_low;
    // initial content of the slot being popped: base + ids - count
    assign s_init_id  = ID_W'(s_base + BW'(IDS_PER_OWNER) - BW'(s_cnt));

    assign s_pop_ok  = s_owner_ok && (s_cnt != '0);
    assign s_push_ok = s_owner_ok && s_in_block && (s_cnt < IDS_C);

    always_comb begin
        if (i_owners_in_use == '0) begin
            s_n = N_W'(1);
        end else if (int'(i_owners_in_use) > OWNERS) begin
            s_n = N_W'(OWNERS);
        end else begin
            s_n = N_W'(i_owners_in_use);
        end
    end

    assign s_score   = signed'(SW'(s_cnt)) - signed'(SW'(s_off));
    assign s_take    = (r_idx == '0) || (s_score > r_best_score);
    assign s_win     = s_take ? r_idx : r_best;
    assign s_win_off = s_take ? s_off : r_best_off;
    assign s_last    = (N_W'(r_idx) + N_W'(1)) == s_n;

    assign s_scan_done    = (r_state == S_SCAN) && s_last;
    assign s_do_reset_all = s_accept && (i_req.func == FN_RESET_ALL);
    assign s_do_clear     = s_accept && (i_req.func == FN_CLEAR) && s_owner_ok;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_req.func == FN_ALLOC && s_pop_ok) begin
                        n_state = S_READ;
                    end else if (i_req.func == FN_PICK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (s_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE) && i_res_ready;
        o_mem_re    = s_accept && (i_req.func == FN_ALLOC) && s_pop_ok;
        o_mem_we    = s_accept && (i_req.func == FN_FREE) && s_push_ok;
        o_mem_raddr = AW'(s_base + BW'(s_pop_c));
        o_mem_waddr = AW'(s_base + BW'(s_cnt));
        o_mem_wdata = i_req.id_value;
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int o = 0; o < OWNERS; o++) begin
                r_cnt[o] <= IDS_C;
                r_low[o] <= IDS_C;
                r_off[o] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (s_do_reset_all) begin
                for (int o = 0; o < OWNERS; o++) begin
                    r_cnt[o] <= IDS_C;
                    r_low[o] <= IDS_C;
                    r_off[o] <= '0;
                end
            end
            if (o_mem_re) begin
                r_cnt[s_sel] <= s_pop_c;
                if (s_fresh) begin
                    r_low[s_sel] <= s_pop_c;
                end
            end
            if (o_mem_we) begin
                r_cnt[s_sel] <= s_cnt + 1'b1;
            end
            if (s_do_clear) begin
                r_off[s_sel] <= '0;
            end
            if (s_scan_done && s_win_off < OFF_MAX) begin
                r_off[s_win] <= s_win_off + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_res     <= '0;
            r_fresh   <= s_fresh;
            r_init_id <= s_init_id;
            r_idx     <= '0;
            case (i_req.func)
                FN_ALLOC: begin
                    if (!s_pop_ok) begin
                        r_res.status <= STS_EMPTY;
                    end
                end
                FN_FREE: begin
                    if (!(s_owner_ok && s_in_block)) begin
                        r_res.status <= STS_WRONG_OWNER;
                    end else if (s_cnt >= IDS_C) begin
                        r_res.status <= STS_FULL;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_READ) begin
            r_res.id_out <= r_fresh ? r_init_id : i_mem_rdata;
        end
        if (r_state == S_SCAN) begin
            if (s_take) begin
                r_best       <= r_idx;
                r_best_score <= s_score;
                r_best_off   <= s_off;
            end
            r_idx <= r_idx + 1'b1;
            if (s_last) begin
                r_res.owner_out <= OWN_W'(s_win);
            end
        end
    end

    a_read_follows_issue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_re |=> (r_state == S_READ))
        else $error("stack read issued without entering read state");

    a_scan_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !s_last) |=>
            (r_state == S_SCAN) && (r_idx == OW_W'($past(r_idx) + 1'b1)))
        else $error("pick scan skipped or left early");

    a_low_mark : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_low <= s_cnt)
        else $error("low-water mark above stack count");

    a_done_returns_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_state == S_IDLE))
        else $error("result delivered but sequencer not idle");

endmodule

`default_nettype wire

### src/per_owner_id_pool_allocator.sv
// flow: free, clear offset, reset all, unused codes and allocate from an empty owner go
// to done; allocate passes the read state for the stack read; pick scans n owners one a cycle
// throughput: one request at a time, next request taken once the result is handed to the
// output register, which holds it while the next request runs
// reset: synchronous, counts full and offsets zero; reset all requests do the same, and
// untouched stack slots read as their initial id through a per-owner low-water mark
`default_nettype none

module per_owner_id_pool_allocator #(
    parameter int OWNERS        = 8,
    parameter int IDS_PER_OWNER = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [2:0] owner, [13:3] id_value, [15:14] zero
    input  wire logic [poia_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [2:0] func
    input  wire logic [poia_pkg::FUNC_W-1:0]      i_s_tuser,
    // result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [10:0] id_out, [13:11] owner_out, [15:14] status
    output logic      [poia_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [poia_pkg::APB_AW-1:0]      paddr,
    input  wire logic [poia_pkg::APB_DW-1:0]      pwdata,
    output logic      [poia_pkg::APB_DW-1:0]      prdata,
    output logic                                  pready
);
    import poia_pkg::*;

    localparam int DEPTH = OWNERS * IDS_PER_OWNER;
    localparam int AW    = $clog2(DEPTH);

    logic [OIU_W-1:0]       r_owners_in_use;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    t_req            s_req;
    t_res            s_res;
    logic            s_res_valid;
    logic            s_res_ready;
    logic            s_mem_we;
    logic [AW-1:0]   s_mem_waddr;
    logic [ID_W-1:0] s_mem_wdata;
    logic            s_mem_re;
    logic [AW-1:0]   s_mem_raddr;
    logic [ID_W-1:0] s_mem_rdata;
    logic            s_cfg_write;
    logic            s_reg_sel;

    assign s_req.func     = i_s_tuser;
    assign s_req.owner    = i_s_tdata[OWN_W-1:0];
    assign s_req.id_value = i_s_tdata[OWN_W+ID_W-1:OWN_W];

    // configuration register
    assign pready      = 1'b1;
    assign s_reg_sel   = (paddr[2] == REG_OWNERS_IN_USE);
    assign s_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owners_in_use <= OIU_W'(OWNERS);
        end else if (s_cfg_write && s_reg_sel) begin
            r_owners_in_use <= OIU_W'(pwdata[CFG_W-1:0]);
        end
    end

    assign prdata = s_reg_sel ? APB_DW'(r_owners_in_use) : '0;

    // output register, refilled in the cycle it is taken
    assign s_res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res_valid) begin
            r_m_data <= OUT_TDATA_W'({s_res.status, s_res.owner_out, s_res.id_out});
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    poia_ctrl #(
        .OWNERS        (OWNERS),
        .IDS_PER_OWNER (IDS_PER_OWNER),
        .AW            (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (s_req),
        .i_req_valid     (i_s_tvalid),
        .o_req_ready     (o_s_tready),
        .i_owners_in_use (r_owners_in_use),
        .o_res           (s_res),
        .o_res_valid     (s_res_valid),
        .i_res_ready     (s_res_ready),
        .o_mem_we        (s_mem_we),
        .o_mem_waddr     (s_mem_waddr),
        .o_mem_wdata     (s_mem_wdata),
        .o_mem_re        (s_mem_re),
        .o_mem_raddr     (s_mem_raddr),
        .i_mem_rdata     (s_mem_rdata)
    );

    poia_stack_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (s_mem_waddr),
        .i_wdata (s_mem_wdata),
        .i_re    (s_mem_re),
        .i_raddr (s_mem_raddr),
        .o_rdata (s_mem_rdata)
    );

endmodule

`default_nettype wire
